/* sv/q24_8_fixed_point_alu_assert.svh */
// Assertion macros used by the checker file of the fixed-point unit.
`ifndef Q24_8_FIXED_POINT_ALU_ASSERT_SVH
`define Q24_8_FIXED_POINT_ALU_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define FXA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold outside reset.
`define FXA_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

/* sv/fxa_pkg.sv */
// ----------------------------------------------------------------------------
// fxa_pkg
// Shared types and constants of the Q24.8 fixed-point unit.
// ----------------------------------------------------------------------------
package fxa_pkg;

  localparam int FracBitsDef   = 8;
  localparam int QueueDepthDef = 2;

  typedef enum logic [4:0] {
    OpAdd       = 5'd0,
    OpSub       = 5'd1,
    OpMul       = 5'd2,
    OpDiv       = 5'd3,
    OpLt        = 5'd4,
    OpLe        = 5'd5,
    OpGt        = 5'd6,
    OpGe        = 5'd7,
    OpEq        = 5'd8,
    OpNe        = 5'd9,
    OpInc       = 5'd10,
    OpDec       = 5'd11,
    OpMin       = 5'd12,
    OpMax       = 5'd13,
    OpFromInt   = 5'd14,
    OpToInt     = 5'd15,
    OpFromFloat = 5'd16,
    OpToFloat   = 5'd17,
    OpNone      = 5'd31
  } fxa_op_e;

  localparam logic [4:0] OpLastCode = 5'd17;

  typedef struct packed {
    fxa_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] intv;
    logic [31:0] fbits;
  } fxa_item_t;

endpackage

/* sv/fxa_front.sv */
// ----------------------------------------------------------------------------
// fxa_front
// Accepts commands and classifies the operation code before queueing.
// ----------------------------------------------------------------------------
module fxa_front (
  input  logic              start,
  input  logic              full_i,
  input  logic [4:0]        operation_i,
  input  logic [31:0]       raw_a_i,
  input  logic [31:0]       raw_b_i,
  input  logic [31:0]       int_value_i,
  input  logic [31:0]       float_bits_i,
  output logic              push_o,
  output fxa_pkg::fxa_item_t item_o
);
  import fxa_pkg::*;

  assign push_o = start & ~full_i;

  always_comb begin
    // Codes past the last operation produce an all-zero result.
    if (operation_i <= OpLastCode) begin
      item_o.op = fxa_op_e'(operation_i);
    end else begin
      item_o.op = OpNone;
    end
    item_o.a     = raw_a_i;
    item_o.b     = raw_b_i;
    item_o.intv  = int_value_i;
    item_o.fbits = float_bits_i;
  end

endmodule

/* sv/fxa_queue.sv */
// ----------------------------------------------------------------------------
// fxa_queue
// Short FIFO that decouples command acceptance from execution.
// ----------------------------------------------------------------------------
module fxa_queue #(
  parameter int DEPTH = fxa_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fxa_pkg::fxa_item_t push_item_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               empty_o,
  output fxa_pkg::fxa_item_t pop_item_o
);
  import fxa_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  fxa_item_t        mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_pop;

  assign full_o     = (cnt_q == CntW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_pop     = pop_i & ~empty_o;
  assign pop_item_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

/* sv/fxa_back.sv */
// ----------------------------------------------------------------------------
// fxa_back
// Execution pipeline: operand stage with multiplier, one restoring divider
// step per stage, quotient select, and a two-stage fixed-to-float converter.
// ----------------------------------------------------------------------------
module fxa_back #(
  parameter int FRAC_BITS = fxa_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  fxa_pkg::fxa_item_t item_i,
  output logic               done_o,
  output logic [31:0]        raw_result_o,
  output logic [23:0]        int_result_o,
  output logic [31:0]        float_result_o,
  output logic               compare_true_o,
  output logic               divide_by_zero_o
);
  import fxa_pkg::*;

  localparam int DW = 32 + FRAC_BITS;

  typedef struct packed {
    fxa_op_e     op;
    logic [31:0] r;
    logic        cmp;
    logic        dz;
    logic        neg;
    logic [31:0] dvs;
  } side_t;

  function automatic logic [31:0] from_float(input logic [31:0] f);
    logic              s;
    logic [7:0]        e;
    logic [63:0]       m;
    logic [63:0]       mag;
    logic signed [10:0] sh;
    logic [10:0]       n;
    logic [31:0]       res;
    s   = f[31];
    e   = f[30:23];
    m   = {40'd0, 1'b1, f[22:0]};
    sh  = $signed({3'd0, e}) - 11'sd150 + 11'(FRAC_BITS);
    mag = '0;
    if (sh > 11'sd40) begin
      mag = 64'h0000_00FF_FFFF_FFFF;
    end else if (sh >= 11'sd0) begin
      mag = m << sh[5:0];
    end else begin
      n = 11'(-sh);
      if (n > 11'd25) begin
        mag = '0;
      end else begin
        mag = (m + (64'd1 << (n[4:0] - 5'd1))) >> n[4:0];
      end
    end
    if (!s && mag > 64'h7FFF_FFFF) begin
      res = 32'h7FFF_FFFF;
    end else if (s && mag > 64'h8000_0000) begin
      res = 32'h8000_0000;
    end else if (s) begin
      res = 32'd0 - mag[31:0];
    end else begin
      res = mag[31:0];
    end
    if (e == 8'hFF) begin
      res = (f[22:0] != '0) ? 32'd0 : (s ? 32'h8000_0000 : 32'h7FFF_FFFF);
    end else if (e == 8'h00) begin
      res = 32'd0;
    end
    return res;
  endfunction

  // Operand stage.
  logic signed [63:0] prod;
  logic signed [31:0] sa, sb;
  logic [31:0]        absa;
  side_t              side0;

  assign sa   = $signed(item_i.a);
  assign sb   = $signed(item_i.b);
  assign prod = sa * sb;
  assign absa = sa[31] ? 32'd0 - item_i.a : item_i.a;

  always_comb begin
    side0     = '0;
    side0.op  = item_i.op;
    side0.neg = item_i.a[31] ^ item_i.b[31];
    side0.dvs = item_i.b[31] ? 32'd0 - item_i.b : item_i.b;
    case (item_i.op)
      OpAdd:       side0.r = item_i.a + item_i.b;
      OpSub:       side0.r = item_i.a - item_i.b;
      OpMul:       side0.r = prod[FRAC_BITS +: 32];
      OpDiv:       side0.dz = (item_i.b == '0);
      OpLt:        side0.cmp = sa < sb;
      OpLe:        side0.cmp = sa <= sb;
      OpGt:        side0.cmp = sa > sb;
      OpGe:        side0.cmp = sa >= sb;
      OpEq:        side0.cmp = sa == sb;
      OpNe:        side0.cmp = sa != sb;
      OpInc:       side0.r = item_i.a + 32'd1;
      OpDec:       side0.r = item_i.a - 32'd1;
      OpMin:       side0.r = (sa < sb) ? item_i.a : item_i.b;
      OpMax:       side0.r = (sa > sb) ? item_i.a : item_i.b;
      OpFromInt:   side0.r = item_i.intv << FRAC_BITS;
      OpToInt:     side0.r = item_i.a;
      OpFromFloat: side0.r = from_float(item_i.fbits);
      OpToFloat:   side0.r = item_i.a;
      default:     side0.r = '0;
    endcase
  end

  // Divider pipeline; stage 0 is the operand register.
  logic [DW:0]    vld_q;
  side_t          side_q [DW+1];
  logic [DW-1:0]  qd_q   [DW+1];
  logic [31:0]    rem_q  [DW+1];
  logic [32:0]    trial  [DW];
  logic [DW-1:0]  qbit;

  always_comb begin
    for (int k = 0; k < DW; k++) begin
      trial[k] = {rem_q[k], qd_q[k][DW-1]};
      qbit[k]  = (trial[k] >= {1'b0, side_q[k].dvs});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side0;
    qd_q[0]   <= {absa, {FRAC_BITS{1'b0}}};
    rem_q[0]  <= '0;
    for (int k = 0; k < DW; k++) begin
      side_q[k+1] <= side_q[k];
      qd_q[k+1]   <= {qd_q[k][DW-2:0], qbit[k]};
      rem_q[k+1]  <= qbit[k] ? 32'(trial[k] - {1'b0, side_q[k].dvs}) : trial[k][31:0];
    end
  end

  // Quotient select.
  logic        sel_v_q, sel_cmp_q, sel_dz_q;
  logic [31:0] sel_r_q, sel_r_d, quot;

  assign quot = qd_q[DW][31:0];

  always_comb begin
    sel_r_d = side_q[DW].r;
    if (side_q[DW].op == OpDiv) begin
      if (side_q[DW].dz) begin
        sel_r_d = '0;
      end else begin
        sel_r_d = side_q[DW].neg ? 32'd0 - quot : quot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_v_q <= 1'b0;
    end else begin
      sel_v_q <= vld_q[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    sel_r_q   <= sel_r_d;
    sel_cmp_q <= side_q[DW].cmp;
    sel_dz_q  <= side_q[DW].dz;
  end

  // Float stage A: magnitude and leading-one position.
  logic        fa_v_q, fa_cmp_q, fa_dz_q, fa_s_q;
  logic [31:0] fa_r_q, fa_mag_q, mag_d;
  logic [4:0]  fa_p_q, p_d;

  assign mag_d = sel_r_q[31] ? 32'd0 - sel_r_q : sel_r_q;

  always_comb begin
    p_d = '0;
    for (int i = 0; i < 32; i++) begin
      if (mag_d[i]) begin
        p_d = 5'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fa_v_q <= 1'b0;
    end else begin
      fa_v_q <= sel_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fa_r_q   <= sel_r_q;
    fa_cmp_q <= sel_cmp_q;
    fa_dz_q  <= sel_dz_q;
    fa_s_q   <= sel_r_q[31];
    fa_mag_q <= mag_d;
    fa_p_q   <= p_d;
  end

  // Float stage B: round to nearest even, pack, and form the integer view.
  logic [31:0]        flt_d, rem_f, half_f, mask_f;
  logic [24:0]        keep;
  logic [5:0]         pe;
  logic [4:0]         nsh;
  logic [8:0]         expo;
  logic signed [31:0] ishift;

  always_comb begin
    pe     = {1'b0, fa_p_q};
    nsh    = '0;
    mask_f = '0;
    rem_f  = '0;
    half_f = '0;
    if (fa_p_q <= 5'd23) begin
      keep = 25'(fa_mag_q << (5'd23 - fa_p_q));
    end else begin
      nsh    = fa_p_q - 5'd23;
      mask_f = (32'd1 << nsh) - 32'd1;
      rem_f  = fa_mag_q & mask_f;
      half_f = 32'd1 << (nsh - 5'd1);
      keep   = 25'(fa_mag_q >> nsh);
      if (rem_f > half_f || (rem_f == half_f && keep[0])) begin
        keep = keep + 25'd1;
      end
      if (keep[24]) begin
        keep = keep >> 1;
        pe   = pe + 6'd1;
      end
    end
    expo  = 9'(pe) + 9'd127 - 9'(FRAC_BITS);
    flt_d = (fa_mag_q == '0) ? 32'd0 : {fa_s_q, expo[7:0], keep[22:0]};
  end

  assign ishift = $signed(fa_r_q) >>> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o           <= 1'b0;
      compare_true_o   <= 1'b0;
      divide_by_zero_o <= 1'b0;
    end else begin
      done_o           <= fa_v_q;
      compare_true_o   <= fa_v_q & fa_cmp_q;
      divide_by_zero_o <= fa_v_q & fa_dz_q;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_result_o   <= fa_r_q;
    int_result_o   <= ishift[23:0];
    float_result_o <= flt_d;
  end

endmodule

/* sv/q24_8_fixed_point_alu.sv */
// ----------------------------------------------------------------------------
// q24_8_fixed_point_alu
// Signed fixed-point arithmetic unit, one command per cycle while busy is low.
// ----------------------------------------------------------------------------
// A command is taken on each clock edge with start high and busy low, one per
// cycle. Every command returns one result beat, marked by done_o for a single
// cycle, in command order; the receiver cannot stall. All operations share one
// pipeline whose depth is set by the divider, one quotient bit per stage.
// busy rises only if the two-entry command queue fills.
module q24_8_fixed_point_alu #(
  parameter int FRAC_BITS   = fxa_pkg::FracBitsDef,
  parameter int QUEUE_DEPTH = fxa_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  operation_i,
  input  logic [31:0] raw_a_i,
  input  logic [31:0] raw_b_i,
  input  logic [31:0] int_value_i,
  input  logic [31:0] float_bits_i,
  output logic        done_o,
  output logic [31:0] raw_result_o,
  output logic [23:0] int_result_o,
  output logic [31:0] float_result_o,
  output logic        compare_true_o,
  output logic        divide_by_zero_o
);
  import fxa_pkg::*;

  fxa_item_t push_item, pop_item;
  logic      push, full, empty;

  fxa_front u_front (
    .start        (start),
    .full_i       (full),
    .operation_i  (operation_i),
    .raw_a_i      (raw_a_i),
    .raw_b_i      (raw_b_i),
    .int_value_i  (int_value_i),
    .float_bits_i (float_bits_i),
    .push_o       (push),
    .item_o       (push_item)
  );

  fxa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (1'b1),
    .full_o      (full),
    .empty_o     (empty),
    .pop_item_o  (pop_item)
  );

  fxa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (~empty),
    .item_i           (pop_item),
    .done_o           (done_o),
    .raw_result_o     (raw_result_o),
    .int_result_o     (int_result_o),
    .float_result_o   (float_result_o),
    .compare_true_o   (compare_true_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

  assign busy = full;

endmodule

/* sv/fxa_checker.sv */
// ----------------------------------------------------------------------------
// fxa_checker
// Port-level checks on the result beats of the fixed-point unit.
// ----------------------------------------------------------------------------
`include "q24_8_fixed_point_alu_assert.svh"

module fxa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        done_o,
  input logic [31:0] raw_result_o,
  input logic [23:0] int_result_o,
  input logic [31:0] float_result_o,
  input logic        compare_true_o,
  input logic        divide_by_zero_o
);

  `FXA_ASSERT(a_cmp_in_beat, compare_true_o |-> done_o, "compare flag outside a beat")
  `FXA_ASSERT(a_dz_zero, divide_by_zero_o |-> (done_o && raw_result_o == 32'd0), "bad dz beat")
  `FXA_NEVER(a_flags_excl, compare_true_o && divide_by_zero_o, "both flags set")
  `FXA_ASSERT(a_cmp_no_value, compare_true_o |-> (raw_result_o == 32'd0 && int_result_o == 24'd0 && float_result_o == 32'd0), "comparison carries a value")

endmodule

bind q24_8_fixed_point_alu fxa_checker u_fxa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .done_o           (done_o),
  .raw_result_o     (raw_result_o),
  .int_result_o     (int_result_o),
  .float_result_o   (float_result_o),
  .compare_true_o   (compare_true_o),
  .divide_by_zero_o (divide_by_zero_o)
);

/* tb/sv/tb_q24_8_fixed_point_alu.sv */
// ----------------------------------------------------------------------------
// tb_q24_8_fixed_point_alu
// Drives random and corner-case commands into the Q24.8 unit, predicts each
// result beat and compares it field by field against the output stream.
// ----------------------------------------------------------------------------

class fxa_result_board;
  typedef struct {
    logic [31:0] raw;
    logic [23:0] ival;
    logic [31:0] fval;
    logic        cmp;
    logic        dz;
  } fxa_result_t;

  fxa_result_t pending_q[$];
  int          err_cnt;

  // Float pattern to fixed point, rounding half away from zero, saturating.
  function automatic logic [31:0] float_to_fix(logic [31:0] f);
    logic        s;
    logic [7:0]  e;
    logic [23:0] m;
    logic [63:0] mag;
    int          sh;
    s = f[31];
    e = f[30:23];
    m = {1'b1, f[22:0]};
    if (e == 8'hFF) return (f[22:0] != 0) ? 32'h0 : (s ? 32'h8000_0000 : 32'h7FFF_FFFF);
    if (e == 8'h00) return 32'h0;
    sh = int'(e) - 150 + fxa_pkg::FracBitsDef;
    if (sh > 40) mag = 64'hFF_FFFF_FFFF;
    else if (sh >= 0) mag = 64'(m) << sh;
    else if (-sh > 25) mag = 0;
    else mag = (64'(m) + (64'd1 << (-sh - 1))) >> (-sh);
    if (!s && mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    if (s && mag > 64'h8000_0000) return 32'h8000_0000;
    return s ? 32'(0 - mag[31:0]) : mag[31:0];
  endfunction

  // Fixed point to float, round to nearest, ties to even.
  function automatic logic [31:0] fix_to_float(logic [31:0] r);
    logic [31:0] mag, keep, rem, half;
    int          p, n;
    mag = r[31] ? 32'(0 - r) : r;
    if (mag == 0) return 32'h0;
    p = 31;
    while (!mag[p]) p--;
    if (p <= 23) keep = mag << (23 - p);
    else begin
      n = p - 23;
      rem = mag & ((32'd1 << n) - 1);
      half = 32'd1 << (n - 1);
      keep = mag >> n;
      if (rem > half || (rem == half && keep[0])) keep++;
      if (keep == 32'h100_0000) begin
        keep >>= 1;
        p++;
      end
    end
    return {r[31], 8'(p - fxa_pkg::FracBitsDef + 127), keep[22:0]};
  endfunction

  function void note_command(logic [4:0] op, logic [31:0] a, logic [31:0] b,
                             logic [31:0] iv, logic [31:0] fb);
    fxa_result_t  x;
    logic signed [31:0] sa, sb;
    logic signed [63:0] prod, num;
    logic         has_val;
    logic [31:0]  r;
    sa = a;
    sb = b;
    r = 0;
    has_val = 1;
    x.cmp = 0;
    x.dz = 0;
    case (op)
      fxa_pkg::OpAdd: r = a + b;
      fxa_pkg::OpSub: r = a - b;
      fxa_pkg::OpMul: begin
        prod = 64'(sa) * 64'(sb);
        r = 32'(prod >>> fxa_pkg::FracBitsDef);
      end
      fxa_pkg::OpDiv: begin
        if (b == 0) x.dz = 1;
        else begin
          num = 64'(sa) <<< fxa_pkg::FracBitsDef;
          r = 32'(num / 64'(sb));
        end
      end
      fxa_pkg::OpLt: begin x.cmp = sa < sb;  has_val = 0; end
      fxa_pkg::OpLe: begin x.cmp = sa <= sb; has_val = 0; end
      fxa_pkg::OpGt: begin x.cmp = sa > sb;  has_val = 0; end
      fxa_pkg::OpGe: begin x.cmp = sa >= sb; has_val = 0; end
      fxa_pkg::OpEq: begin x.cmp = sa == sb; has_val = 0; end
      fxa_pkg::OpNe: begin x.cmp = sa != sb; has_val = 0; end
      fxa_pkg::OpInc: r = a + 1;
      fxa_pkg::OpDec: r = a - 1;
      fxa_pkg::OpMin: r = (sa < sb) ? a : b;
      fxa_pkg::OpMax: r = (sa > sb) ? a : b;
      fxa_pkg::OpFromInt: r = iv << fxa_pkg::FracBitsDef;
      fxa_pkg::OpToInt, fxa_pkg::OpToFloat: r = a;
      fxa_pkg::OpFromFloat: r = float_to_fix(fb);
      default: has_val = 0;
    endcase
    x.raw  = has_val ? r : 32'h0;
    x.ival = has_val ? 24'($signed(r) >>> fxa_pkg::FracBitsDef) : 24'h0;
    x.fval = has_val ? fix_to_float(r) : 32'h0;
    pending_q.push_back(x);
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    err_cnt++;
  endtask

  task check_beat(logic [31:0] raw, logic [23:0] ival, logic [31:0] fval,
                  logic cmp, logic dz);
    fxa_result_t w;
    if (pending_q.size() == 0) begin
      report_mismatch("unexpected beat", raw, 0);
      return;
    end
    w = pending_q.pop_front();
    if (raw !== w.raw)   report_mismatch("raw_result", raw, w.raw);
    if (ival !== w.ival) report_mismatch("int_result", 32'(ival), 32'(w.ival));
    if (fval !== w.fval) report_mismatch("float_result", fval, w.fval);
    if (cmp !== w.cmp)   report_mismatch("compare_true", 32'(cmp), 32'(w.cmp));
    if (dz !== w.dz)     report_mismatch("divide_by_zero", 32'(dz), 32'(w.dz));
  endtask
endclass

module tb_q24_8_fixed_point_alu;
  import fxa_pkg::*;

  localparam int Latency   = FracBitsDef + 37;
  localparam int StallLimit = 2000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [4:0]  operation_i = 0;
  logic [31:0] raw_a_i = 0, raw_b_i = 0, int_value_i = 0, float_bits_i = 0;
  logic        done_o;
  logic [31:0] raw_result_o, float_result_o;
  logic [23:0] int_result_o;
  logic        compare_true_o, divide_by_zero_o;

  fxa_result_board board = new();
  int          idle_cycles;
  bit          quiet_mode;

  q24_8_fixed_point_alu dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy)
      board.note_command(operation_i, raw_a_i, raw_b_i, int_value_i, float_bits_i);
    if (rst_ni && done_o)
      board.check_beat(raw_result_o, int_result_o, float_result_o,
                       compare_true_o, divide_by_zero_o);
    if ((rst_ni && start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (idle_cycles > StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4: return 32'($signed($urandom_range(0, 4096)) - 2048);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_float();
    logic [31:0] f;
    f = $urandom();
    case ($urandom_range(0, 5))
      0: f[30:23] = 8'($urandom_range(110, 160));
      1: f[30:23] = 8'($urandom_range(140, 175));
      2: f[30:23] = 8'($urandom_range(0, 1) ? 8'hFF : 8'h00);
      default: ;
    endcase
    return f;
  endfunction

  // Presents one command from the falling edge and holds it until accepted.
  // start stays high afterwards so back-to-back commands need no gap.
  task automatic send_cmd(logic [4:0] op, logic [31:0] a, logic [31:0] b,
                          logic [31:0] iv, logic [31:0] fb);
    if (!quiet_mode) begin
      while ($urandom_range(0, 99) < 33) begin
        start <= 0;
        @(negedge clk_i);
      end
    end
    operation_i  <= op;
    raw_a_i      <= a;
    raw_b_i      <= b;
    int_value_i  <= iv;
    float_bits_i <= fb;
    start        <= 1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 0;
    while (board.pending_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int i;
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed corners: every operation, operand extremes, the division cases.
    for (int op = 0; op <= int'(OpLastCode); op++)
      send_cmd(5'(op), 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_cmd(OpDiv, 32'h0000_0100, 32'h0, 0, 0);
    send_cmd(OpDiv, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
    send_cmd(OpFromFloat, 0, 0, 0, 32'h7FC0_0000);
    send_cmd(OpFromFloat, 0, 0, 0, 32'hFF80_0000);
    send_cmd(OpFromFloat, 0, 0, 0, 32'h3B80_0000);
    send_cmd(OpFromFloat, 0, 0, 0, 32'h0000_0001);
    send_cmd(OpNone, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Hold off until the pipeline has emptied, then random traffic.
    drain();
    for (i = 0; i < 1450; i++) begin
      logic [4:0] op;
      quiet_mode = (i >= 500 && i < 700);
      op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
                                        : 5'($urandom_range(0, int'(OpLastCode)));
      send_cmd(op, pick_word(), ($urandom_range(0, 15) == 0) ? 32'h0 : pick_word(),
               pick_word(), pick_float());
      if (i == 900) drain();
    end

    drain();
    repeat (Latency + 10) @(negedge clk_i);
    if (board.err_cnt == 0 && board.pending_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
